### rtl/core/pwlct_pkg.sv
// ----------------------------------------------------------------------------
// pwlct_pkg
// Shared types, widths and codes for the piecewise linear color transfer.
// ----------------------------------------------------------------------------
package pwlct_pkg;

  // Default sizes for the top-level parameters
  localparam int MAX_POINTS_DEF = 16;
  localparam int TABLE_SIZE_DEF = 256;

  // Field widths
  localparam int POS_W    = 17;   // Q1.16 position
  localparam int CH_W     = 16;   // Q6.10 channel
  localparam int IDX_W    = 4;    // point slot field
  localparam int SMP_W    = 8;    // sample index field
  localparam int ACT_W    = 5;    // active point count register
  localparam int T_W      = 24;   // mapped sample position, up to 255 * 65536
  localparam int FRAC_W   = 16;   // quotient bits of the segment fraction
  localparam int SAMPLE_N = 1 << SMP_W;
  localparam int NUM_CH   = 4;

  localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(2);
  localparam logic [CH_W-1:0]  ONE_Q6_10 = CH_W'(1024);
  localparam logic [POS_W-1:0] FRAC_ONE  = POS_W'(1 << FRAC_W);

  // Item command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Channel order inside the interpolation sequencer
  localparam logic [1:0] CH_RED     = 2'd0;
  localparam logic [1:0] CH_GREEN   = 2'd1;
  localparam logic [1:0] CH_BLUE    = 2'd2;
  localparam logic [1:0] CH_OPACITY = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  opacity;
  } point_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] opacity;
  } color_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_LERP
  } state_t;

  // Pick one channel of a control point
  function automatic logic [CH_W-1:0] chan_sel(point_t p, logic [1:0] ch);
    logic [CH_W-1:0] v;
    case (ch)
      CH_RED:     v = p.red;
      CH_GREEN:   v = p.green;
      CH_BLUE:    v = p.blue;
      CH_OPACITY: v = p.opacity;
      default:    v = p.red;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/pwlct_point_mem.sv
// ----------------------------------------------------------------------------
// pwlct_point_mem
// Control point store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pwlct_point_mem #(
  parameter int MAX_POINTS = pwlct_pkg::MAX_POINTS_DEF,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  pwlct_pkg::point_t   wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output pwlct_pkg::point_t   rdata
);

  pwlct_pkg::point_t mem [MAX_POINTS];
  pwlct_pkg::point_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/pwlct_frac_div.sv
// ----------------------------------------------------------------------------
// pwlct_frac_div
// Restoring divider for the segment fraction floor(num * 65536 / den).
// Takes num < den and produces one quotient bit per cycle; num == den
// gives 1.0 directly.
// ----------------------------------------------------------------------------
module pwlct_frac_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [pwlct_pkg::POS_W-1:0]       num,
  input  logic [pwlct_pkg::POS_W-1:0]       den,
  output logic                              done,
  output logic [pwlct_pkg::POS_W-1:0]       frac
);

  localparam int CNT_W = $clog2(pwlct_pkg::FRAC_W);

  logic                               run_r, run_nxt;
  logic                               done_r, done_nxt;
  logic                               full_r, full_nxt;
  logic [CNT_W-1:0]                   cnt_r, cnt_nxt;
  logic [pwlct_pkg::POS_W-1:0]        rem_r, rem_nxt;
  logic [pwlct_pkg::POS_W-1:0]        den_r, den_nxt;
  logic [pwlct_pkg::FRAC_W-1:0]       q_r, q_nxt;
  logic [pwlct_pkg::POS_W:0]          rem_sh;
  logic                               ge;

  // One shift-and-subtract step
  assign rem_sh = {rem_r, 1'b0};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    full_nxt = full_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (start) begin
      rem_nxt  = num;
      den_nxt  = den;
      q_nxt    = '0;
      cnt_nxt  = '0;
      full_nxt = (num == den);
      run_nxt  = (num != den);
      done_nxt = (num == den);
    end else if (run_r) begin
      rem_nxt = ge ? pwlct_pkg::POS_W'(rem_sh - {1'b0, den_r})
                   : rem_sh[pwlct_pkg::POS_W-1:0];
      q_nxt   = {q_r[pwlct_pkg::FRAC_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(pwlct_pkg::FRAC_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      full_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      full_r <= full_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign frac = full_r ? pwlct_pkg::FRAC_ONE : {1'b0, q_r};

endmodule

### rtl/core/pwlct_lerp.sv
// ----------------------------------------------------------------------------
// pwlct_lerp
// Channel interpolator: one shared multiplier, one channel per cycle.
// c = c1 + floor(f * (c2 - c1) / 65536), floored toward minus infinity.
// ----------------------------------------------------------------------------
module pwlct_lerp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pwlct_pkg::POS_W-1:0]   frac,
  input  pwlct_pkg::point_t             p1,
  input  pwlct_pkg::point_t             p2,
  output logic                          done,
  output pwlct_pkg::color_t             color
);

  localparam int CH_W   = pwlct_pkg::CH_W;
  localparam int CHC_W  = $clog2(pwlct_pkg::NUM_CH + 1);
  localparam int PROD_W = 2 * CH_W;

  logic                         run_r;
  logic                         done_r;
  logic [CHC_W-1:0]             ch_r;
  logic [CHC_W-1:0]             ch_prev;
  logic [pwlct_pkg::POS_W-1:0]  frac_r;
  logic [PROD_W-1:0]            prod_r;
  logic                         neg_r;
  logic [CH_W-1:0]              c1_r;
  logic [CH_W-1:0]              res_r [pwlct_pkg::NUM_CH];
  logic [CH_W-1:0]              c1_sel, c2_sel, diff;
  logic [CH_W-1:0]              up, down;
  logic [PROD_W:0]              prod_rnd;

  // Operand selection for the channel in flight
  assign c1_sel  = pwlct_pkg::chan_sel(p1, ch_r[1:0]);
  assign c2_sel  = pwlct_pkg::chan_sel(p2, ch_r[1:0]);
  assign diff    = (c2_sel >= c1_sel) ? CH_W'(c2_sel - c1_sel) : CH_W'(c1_sel - c2_sel);
  assign ch_prev = ch_r - CHC_W'(1);

  // Finishing step on the registered product
  assign up       = prod_r[PROD_W-1:CH_W];
  assign prod_rnd = {1'b0, prod_r} + (PROD_W+1)'((1 << CH_W) - 1);
  assign down     = prod_rnd[PROD_W-1:CH_W];

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ch_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        ch_r  <= '0;
      end else if (run_r) begin
        ch_r <= ch_r + CHC_W'(1);
        if (ch_r == CHC_W'(pwlct_pkg::NUM_CH)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Multiply one channel, finish the one before it
  always_ff @(posedge clk) begin
    if (start) begin
      frac_r <= frac;
    end else if (run_r) begin
      if (ch_r < CHC_W'(pwlct_pkg::NUM_CH)) begin
        prod_r <= PROD_W'(frac_r) * PROD_W'(diff);
        neg_r  <= c2_sel < c1_sel;
        c1_r   <= c1_sel;
      end
      if (ch_r != '0) begin
        res_r[ch_prev[1:0]] <= neg_r ? CH_W'(c1_r - down) : CH_W'(c1_r + up);
      end
    end
  end

  assign done          = done_r;
  assign color.red     = res_r[pwlct_pkg::CH_RED];
  assign color.green   = res_r[pwlct_pkg::CH_GREEN];
  assign color.blue    = res_r[pwlct_pkg::CH_BLUE];
  assign color.opacity = res_r[pwlct_pkg::CH_OPACITY];

endmodule

### rtl/core/piecewise_linear_color_transfer.sv
// ----------------------------------------------------------------------------
// piecewise_linear_color_transfer
// Piecewise linear color and opacity lookup over stored control points.
// ----------------------------------------------------------------------------
// A load item (in_command = 0) writes one control point in the accept cycle
// and gives no result. A query item maps in_sample_index to a position
// through a constant table, then streams the control points out of the point
// memory one per cycle, testing each segment as its end point arrives. A
// query's run time is set by the point memory's single read port, the 16-step
// fraction divider and the shared multiplier that serves the four channels
// in turn. busy is high while a query is in flight. Each result shows for
// exactly one cycle with out_strobe; the receiver must take it then. Write
// cfg_wdata (active point count) only while busy is low and no result is due.
// The point memory has no reset; every point in use must be loaded first.
// ----------------------------------------------------------------------------
module piecewise_linear_color_transfer #(
  parameter int MAX_POINTS = pwlct_pkg::MAX_POINTS_DEF,
  parameter int TABLE_SIZE = pwlct_pkg::TABLE_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [pwlct_pkg::ACT_W-1:0]       cfg_wdata,
  // items
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [pwlct_pkg::IDX_W-1:0]       in_point_index,
  input  logic [pwlct_pkg::POS_W-1:0]       in_point_pos,
  input  logic [pwlct_pkg::CH_W-1:0]        in_red_in,
  input  logic [pwlct_pkg::CH_W-1:0]        in_green_in,
  input  logic [pwlct_pkg::CH_W-1:0]        in_blue_in,
  input  logic [pwlct_pkg::CH_W-1:0]        in_opacity_in,
  input  logic [pwlct_pkg::SMP_W-1:0]       in_sample_index,
  // results
  output logic                              out_strobe,
  output logic [pwlct_pkg::CH_W-1:0]        out_red_out,
  output logic [pwlct_pkg::CH_W-1:0]        out_green_out,
  output logic [pwlct_pkg::CH_W-1:0]        out_blue_out,
  output logic [pwlct_pkg::CH_W-1:0]        out_opacity_out,
  output logic                              out_in_range
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int POS_W = pwlct_pkg::POS_W;
  localparam int T_W   = pwlct_pkg::T_W;

  pwlct_pkg::state_t            state_r, state_nxt;
  logic [pwlct_pkg::ACT_W-1:0]  act_r;
  logic [CW-1:0]                n_r, n_nxt, n_cfg;
  logic [CW-1:0]                addr_r, addr_nxt;
  logic                         rd_vld_r, rd_last_r;
  logic                         first_r, first_nxt;
  logic [T_W-1:0]               t_r, t_nxt;
  pwlct_pkg::point_t            prev_r, prev_nxt;
  pwlct_pkg::point_t            cur_r, cur_nxt;
  pwlct_pkg::color_t            res_r, res_nxt;
  logic                         hit_r, hit_nxt;
  logic                         strobe_r, strobe_nxt;

  logic                         accept, slot_ok, issue;
  logic                         mem_we;
  pwlct_pkg::point_t            mem_wdata, rdata;
  logic                         seg_hit;
  logic [POS_W-1:0]             seg_num, seg_len;
  logic                         div_start, div_done;
  logic [POS_W-1:0]             frac;
  logic                         lerp_start, lerp_done;
  pwlct_pkg::color_t            lerp_color;
  pwlct_pkg::color_t            dflt_color;
  pwlct_pkg::color_t            prev_color;
  logic [T_W-1:0]               t_tab [pwlct_pkg::SAMPLE_N];

  // Sample index to position, worked out at elaboration
  for (genvar g = 0; g < pwlct_pkg::SAMPLE_N; g++) begin : g_ttab
    assign t_tab[g] = T_W'((g * 65536) / (TABLE_SIZE - 1));
  end

  // Active count clamped to the store depth
  assign n_cfg = (int'(act_r) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(act_r);

  assign accept  = start && (state_r == pwlct_pkg::ST_IDLE);
  assign slot_ok = int'(in_point_index) < MAX_POINTS;
  assign issue   = (state_r == pwlct_pkg::ST_SCAN) && (addr_r < n_r);

  assign mem_wdata.pos     = in_point_pos;
  assign mem_wdata.red     = in_red_in;
  assign mem_wdata.green   = in_green_in;
  assign mem_wdata.blue    = in_blue_in;
  assign mem_wdata.opacity = in_opacity_in;

  // Segment test on the previous point and the one just read
  assign seg_hit = (t_r >= T_W'(prev_r.pos)) && (t_r <= T_W'(rdata.pos));
  assign seg_num = POS_W'(t_r - T_W'(prev_r.pos));
  assign seg_len = POS_W'(rdata.pos - prev_r.pos);

  assign dflt_color.red     = pwlct_pkg::ONE_Q6_10;
  assign dflt_color.green   = pwlct_pkg::ONE_Q6_10;
  assign dflt_color.blue    = pwlct_pkg::ONE_Q6_10;
  assign dflt_color.opacity = '0;

  assign prev_color.red     = prev_r.red;
  assign prev_color.green   = prev_r.green;
  assign prev_color.blue    = prev_r.blue;
  assign prev_color.opacity = prev_r.opacity;

  // Next state and datapath control
  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    addr_nxt   = addr_r;
    first_nxt  = first_r;
    t_nxt      = t_r;
    prev_nxt   = prev_r;
    cur_nxt    = cur_r;
    res_nxt    = res_r;
    hit_nxt    = hit_r;
    strobe_nxt = 1'b0;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    lerp_start = 1'b0;
    case (state_r)
      pwlct_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_command == pwlct_pkg::CMD_LOAD) begin
            mem_we = slot_ok;
          end else begin
            t_nxt = t_tab[in_sample_index];
            if (n_cfg < CW'(2)) begin
              res_nxt    = dflt_color;
              hit_nxt    = 1'b0;
              strobe_nxt = 1'b1;
            end else begin
              n_nxt     = n_cfg;
              addr_nxt  = '0;
              first_nxt = 1'b1;
              state_nxt = pwlct_pkg::ST_SCAN;
            end
          end
        end
      end
      pwlct_pkg::ST_SCAN: begin
        if (issue) begin
          addr_nxt = addr_r + CW'(1);
        end
        if (rd_vld_r) begin
          if (first_r) begin
            prev_nxt  = rdata;
            first_nxt = 1'b0;
          end else if (seg_hit) begin
            cur_nxt = rdata;
            if (seg_len == '0) begin
              // zero-length segment: first point's channels
              res_nxt    = prev_color;
              hit_nxt    = 1'b1;
              strobe_nxt = 1'b1;
              state_nxt  = pwlct_pkg::ST_IDLE;
            end else begin
              div_start = 1'b1;
              state_nxt = pwlct_pkg::ST_DIV;
            end
          end else begin
            prev_nxt = rdata;
            if (rd_last_r) begin
              res_nxt    = dflt_color;
              hit_nxt    = 1'b0;
              strobe_nxt = 1'b1;
              state_nxt  = pwlct_pkg::ST_IDLE;
            end
          end
        end
      end
      pwlct_pkg::ST_DIV: begin
        if (div_done) begin
          lerp_start = 1'b1;
          state_nxt  = pwlct_pkg::ST_LERP;
        end
      end
      pwlct_pkg::ST_LERP: begin
        if (lerp_done) begin
          res_nxt    = lerp_color;
          hit_nxt    = 1'b1;
          strobe_nxt = 1'b1;
          state_nxt  = pwlct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pwlct_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pwlct_pkg::ST_IDLE;
      act_r     <= pwlct_pkg::ACT_RESET;
      rd_vld_r  <= 1'b0;
      first_r   <= 1'b0;
      strobe_r  <= 1'b0;
      n_r       <= '0;
      addr_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      if (cfg_we) begin
        act_r <= cfg_wdata;
      end
      rd_vld_r  <= issue;
      first_r   <= first_nxt;
      strobe_r  <= strobe_nxt;
      n_r       <= n_nxt;
      addr_r    <= addr_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_last_r <= (addr_r == n_r - CW'(1));
    t_r       <= t_nxt;
    prev_r    <= prev_nxt;
    cur_r     <= cur_nxt;
    res_r     <= res_nxt;
    hit_r     <= hit_nxt;
  end

  pwlct_point_mem #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_point_index)),
    .wdata (mem_wdata),
    .re    (issue),
    .raddr (addr_r[AW-1:0]),
    .rdata (rdata)
  );

  pwlct_frac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (seg_num),
    .den   (seg_len),
    .done  (div_done),
    .frac  (frac)
  );

  pwlct_lerp u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .frac  (frac),
    .p1    (prev_r),
    .p2    (cur_r),
    .done  (lerp_done),
    .color (lerp_color)
  );

  assign busy            = (state_r != pwlct_pkg::ST_IDLE);
  assign out_strobe      = strobe_r;
  assign out_red_out     = res_r.red;
  assign out_green_out   = res_r.green;
  assign out_blue_out    = res_r.blue;
  assign out_opacity_out = res_r.opacity;
  assign out_in_range    = hit_r;

endmodule

### rtl/core/pwlct_checker.sv
// ----------------------------------------------------------------------------
// pwlct_port_checks
// Port-level checks for the color transfer block, bound to the top level.
// ----------------------------------------------------------------------------
module pwlct_port_checks (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              in_command,
  input  logic                              out_strobe,
  input  logic [pwlct_pkg::CH_W-1:0]        out_red_out,
  input  logic [pwlct_pkg::CH_W-1:0]        out_green_out,
  input  logic [pwlct_pkg::CH_W-1:0]        out_blue_out,
  input  logic [pwlct_pkg::CH_W-1:0]        out_opacity_out,
  input  logic                              out_in_range
);

  // A load item never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == pwlct_pkg::CMD_LOAD) |=> !out_strobe)
    else $error("result after a load item");

  // A query either answers at once or holds the block busy
  a_query_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == pwlct_pkg::CMD_QUERY) |=> busy || out_strobe)
    else $error("query item dropped");

  // Results only appear once the block is free again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  // Busy only rises on an accepted item
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy without an item");

  // Out-of-range answer is white with zero opacity
  a_default: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_in_range |-> (out_red_out == pwlct_pkg::ONE_Q6_10) &&
      (out_green_out == pwlct_pkg::ONE_Q6_10) &&
      (out_blue_out == pwlct_pkg::ONE_Q6_10) && (out_opacity_out == '0))
    else $error("bad default color");

endmodule

bind piecewise_linear_color_transfer pwlct_port_checks u_pwlct_port_checks (.*);
